FILE: rtl/psnr3_pkg.sv
// ----------------------------------------------------------------------------
// psnr3_pkg
// Shared types, constants and codes of the three-plane PSNR block.
// ----------------------------------------------------------------------------
`default_nettype none

package psnr3_pkg;

    localparam int MAX_SAMPLE_BITS = 16;
    localparam int MAX_PIXELS_LOG2 = 24;
    localparam int SAMPLE_W        = 16;
    localparam int SQ_W            = 2 * SAMPLE_W;
    localparam int SUM_W           = 56;
    localparam int DIM_W           = 13;
    localparam int DIV_W           = 3;
    localparam int BPS_W           = 5;
    localparam int PELS_W          = 2 * DIM_W;
    localparam int CPELS_W         = MAX_PIXELS_LOG2 + 1;
    localparam int PK2_W           = 2 * MAX_SAMPLE_BITS;
    localparam int EXP_W           = 6;
    localparam int FRAC_W          = 16;
    localparam int LOG_W           = EXP_W + FRAC_W;
    localparam int SCALE_W         = 26;
    localparam int PROD_W          = LOG_W + SCALE_W;
    localparam int PSNR_W          = 16;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = 2;
    localparam int QCNT_W          = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 13;

    // 10*log10(2) in Q.24, rounded
    localparam logic [SCALE_W-1:0] TEN_LOG10_2_Q24 = SCALE_W'(50504453);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_PER_SAMPLE = 3'd0,
        CFG_FRAME_WIDTH     = 3'd1,
        CFG_FRAME_HEIGHT    = 3'd2,
        CFG_CHROMA_DIV_H    = 3'd3,
        CFG_CHROMA_DIV_V    = 3'd4
    } cfg_index_t;

    typedef logic [SUM_W-1:0] sum_t;

    // per-frame error sums handed from front to back
    typedef struct packed {
        sum_t [2:0] sums;
    } frame_sums_t;

    typedef struct packed {
        logic        push;
        frame_sums_t entry;
    } sums_push_t;

    // effective settings used by the back end
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [DIV_W-1:0]    div_h;
        logic [DIV_W-1:0]    div_v;
    } psnr_cfg_t;

    typedef struct packed {
        logic       start;
        sum_t       value;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] result;
    } log_rsp_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQ,
        L_ADJ
    } log_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_PELS,
        B_NUM,
        B_SN,
        B_WN,
        B_SS,
        B_WS,
        B_SCALE,
        B_ROUND,
        B_NEXT,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/psnr3_if.sv
// ----------------------------------------------------------------------------
// psnr3 channel interfaces
// Pixel pair, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface psnr3_pix_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     plane;
    logic [psnr3_pkg::SAMPLE_W-1:0] sample_ref;
    logic [psnr3_pkg::SAMPLE_W-1:0] sample_test;
    logic                           end_of_frame;

    modport source (output valid, plane, sample_ref, sample_test, end_of_frame,
                    input ready);
    modport sink   (input valid, plane, sample_ref, sample_test, end_of_frame,
                    output ready);
endinterface

interface psnr3_res_if;
    logic                         valid;
    logic                         ready;
    logic [psnr3_pkg::PSNR_W-1:0] psnr_luma;
    logic [psnr3_pkg::PSNR_W-1:0] psnr_chroma_one;
    logic [psnr3_pkg::PSNR_W-1:0] psnr_chroma_two;
    logic [2:0]                   identical_mask;

    modport source (output valid, psnr_luma, psnr_chroma_one, psnr_chroma_two,
                    identical_mask, input ready);
    modport sink   (input valid, psnr_luma, psnr_chroma_one, psnr_chroma_two,
                    identical_mask, output ready);
endinterface

interface psnr3_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [psnr3_pkg::CFG_IDX_W-1:0]  index;
    logic [psnr3_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/psnr3_front.sv
// ----------------------------------------------------------------------------
// psnr3_front
// Accepts pixel pairs, squares the difference and keeps per-plane sums.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr3_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    psnr3_pix_if.sink                             pixels,
    input  wire logic [psnr3_pkg::QCNT_W-1:0]     q_count,
    output psnr3_pkg::sums_push_t                 push
);

    logic                           accept;
    logic                           a_valid_reg;
    logic [1:0]                     a_plane_reg;
    logic [psnr3_pkg::SAMPLE_W-1:0] a_mag_reg;
    logic                           a_eof_reg;
    logic                           b_valid_reg;
    logic [1:0]                     b_plane_reg;
    logic [psnr3_pkg::SQ_W-1:0]     b_sq_reg;
    logic                           b_eof_reg;
    psnr3_pkg::sum_t [2:0]          sum_reg;
    psnr3_pkg::sum_t [2:0]          sum_add;
    psnr3_pkg::sum_t [2:0]          sum_next;
    logic [psnr3_pkg::SUM_W:0]      wide_add [3];
    logic [psnr3_pkg::QCNT_W:0]     pending;

    // room in the queue for every frame end still in flight
    assign pending = {1'b0, q_count}
                   + (psnr3_pkg::QCNT_W+1)'(a_valid_reg && a_eof_reg)
                   + (psnr3_pkg::QCNT_W+1)'(b_valid_reg && b_eof_reg);
    assign pixels.ready = pending < (psnr3_pkg::QCNT_W+1)'(psnr3_pkg::QDEPTH);
    assign accept = pixels.valid && pixels.ready;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    // absolute difference, then square
    always_ff @(posedge clk)
    begin
        a_plane_reg <= pixels.plane;
        a_eof_reg   <= pixels.end_of_frame;
        a_mag_reg   <= (pixels.sample_ref >= pixels.sample_test)
                     ? pixels.sample_ref - pixels.sample_test
                     : pixels.sample_test - pixels.sample_ref;
        b_plane_reg <= a_plane_reg;
        b_eof_reg   <= a_eof_reg;
        b_sq_reg    <= a_mag_reg * a_mag_reg;
    end

    // saturating accumulation, clear on frame end
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wide_add[k] = {1'b0, sum_reg[k]} + (psnr3_pkg::SUM_W+1)'(b_sq_reg);
            if (b_valid_reg && b_plane_reg == 2'(k))
                sum_add[k] = wide_add[k][psnr3_pkg::SUM_W] ? '1
                           : wide_add[k][psnr3_pkg::SUM_W-1:0];
            else
                sum_add[k] = sum_reg[k];
        end
        push.push       = b_valid_reg && b_eof_reg;
        push.entry.sums = sum_add;
        sum_next        = push.push ? '0 : sum_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

endmodule

`default_nettype wire

FILE: rtl/psnr3_queue.sv
// ----------------------------------------------------------------------------
// psnr3_queue
// Short queue of finished frame sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr3_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire psnr3_pkg::sums_push_t        push,
    input  wire logic                         pop,
    output logic                              head_valid,
    output psnr3_pkg::frame_sums_t            head,
    output logic [psnr3_pkg::QCNT_W-1:0]      count
);

    psnr3_pkg::frame_sums_t              entry_reg [psnr3_pkg::QDEPTH];
    logic [psnr3_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [psnr3_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [psnr3_pkg::QCNT_W-1:0]        count_reg;

    function automatic logic [psnr3_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
        return psnr3_pkg::QCNT_W'(b);
    endfunction

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign count      = count_reg;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_ONE(push.push) - QCNT_ONE(pop);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.push)
            entry_reg[wr_ptr_reg] <= push.entry;
    end

endmodule

`default_nettype wire

FILE: rtl/psnr3_log2.sv
// ----------------------------------------------------------------------------
// psnr3_log2
// Iterative log2 in Q.16: bit-serial normalise, then sixteen squarings.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr3_log2 (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire psnr3_pkg::log_req_t req,
    output psnr3_pkg::log_rsp_t rsp
);

    psnr3_pkg::log_state_t            state_reg;
    psnr3_pkg::log_state_t            state_next;
    psnr3_pkg::sum_t                  v_reg;
    logic [psnr3_pkg::EXP_W-1:0]      e_reg;
    logic [31:0]                      m_reg;
    logic [63:0]                      prod_reg;
    logic [3:0]                       i_reg;
    logic [psnr3_pkg::FRAC_W-1:0]     frac_reg;
    logic                             done_reg;
    logic [32:0]                      sq_shift;

    assign sq_shift   = prod_reg[63:31];
    assign rsp.done   = done_reg;
    assign rsp.result = {e_reg, frac_reg};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psnr3_pkg::L_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psnr3_pkg::L_IDLE:
                if (req.start)
                    state_next = psnr3_pkg::L_NORM;
            psnr3_pkg::L_NORM:
                if (v_reg[psnr3_pkg::SUM_W-1] || e_reg == '0)
                    state_next = psnr3_pkg::L_SQ;
            psnr3_pkg::L_SQ:
                state_next = psnr3_pkg::L_ADJ;
            psnr3_pkg::L_ADJ:
                state_next = (i_reg == '0) ? psnr3_pkg::L_IDLE : psnr3_pkg::L_SQ;
            default:
                state_next = psnr3_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == psnr3_pkg::L_ADJ) && (i_reg == '0);
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            psnr3_pkg::L_IDLE:
                if (req.start)
                begin
                    v_reg    <= req.value;
                    e_reg    <= psnr3_pkg::EXP_W'(psnr3_pkg::SUM_W - 1);
                    frac_reg <= '0;
                    i_reg    <= 4'd15;
                end
            psnr3_pkg::L_NORM:
                if (v_reg[psnr3_pkg::SUM_W-1] || e_reg == '0)
                    m_reg <= v_reg[psnr3_pkg::SUM_W-1 -: 32];
                else
                begin
                    v_reg <= {v_reg[psnr3_pkg::SUM_W-2:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
            psnr3_pkg::L_SQ:
                prod_reg <= m_reg * m_reg;
            psnr3_pkg::L_ADJ:
            begin
                if (sq_shift[32])
                begin
                    frac_reg[i_reg] <= 1'b1;
                    m_reg           <= sq_shift[32:1];
                end
                else
                    m_reg <= sq_shift[31:0];
                i_reg <= i_reg - 1'b1;
            end
            default:
                ;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/psnr3_back.sv
// ----------------------------------------------------------------------------
// psnr3_back
// Per-frame finish: pixel counts, log ratio per plane, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr3_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psnr3_pkg::psnr_cfg_t   cfg,
    input  wire logic               head_valid,
    input  wire psnr3_pkg::frame_sums_t head,
    output logic                    pop,
    psnr3_res_if.source             results
);

    psnr3_pkg::back_state_t              state_reg;
    psnr3_pkg::back_state_t              state_next;
    logic [psnr3_pkg::DIM_W-1:0]         qw_reg;
    logic [psnr3_pkg::DIM_W-1:0]         qh_reg;
    logic [psnr3_pkg::DIV_W-1:0]         rw_reg;
    logic [psnr3_pkg::DIV_W-1:0]         rh_reg;
    logic [3:0]                          cnt_reg;
    logic [psnr3_pkg::PELS_W-1:0]        luma_pels_reg;
    logic [psnr3_pkg::PELS_W-1:0]        chroma_pels_reg;
    logic [psnr3_pkg::PK2_W-1:0]         pk2_reg;
    psnr3_pkg::sum_t                     num_reg;
    logic [psnr3_pkg::LOG_W-1:0]         ln_reg;
    logic [psnr3_pkg::LOG_W-1:0]         d_reg;
    logic [psnr3_pkg::PROD_W-1:0]        prod_reg;
    logic [1:0]                          k_reg;
    logic [psnr3_pkg::PSNR_W-1:0]        psnr_reg [3];
    logic [2:0]                          mask_reg;
    logic                                out_valid_reg;
    logic [psnr3_pkg::PSNR_W-1:0]        out_luma_reg;
    logic [psnr3_pkg::PSNR_W-1:0]        out_c1_reg;
    logic [psnr3_pkg::PSNR_W-1:0]        out_c2_reg;
    logic [2:0]                          out_mask_reg;
    logic [psnr3_pkg::DIV_W:0]           tw;
    logic [psnr3_pkg::DIV_W:0]           th;
    logic                                gw;
    logic                                gh;
    logic [psnr3_pkg::PELS_W-1:0]        pels_sel;
    logic [psnr3_pkg::CPELS_W-1:0]       pels_clamped;
    psnr3_pkg::sum_t                     cur_sum;
    logic [psnr3_pkg::LOG_W:0]           diff;
    logic [psnr3_pkg::PROD_W:0]          rounded;
    logic                                out_free;
    psnr3_pkg::log_req_t                 log_req;
    psnr3_pkg::log_rsp_t                 log_rsp;

    psnr3_log2 u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    // restoring divide steps for the chroma dimensions
    assign tw = {rw_reg, qw_reg[psnr3_pkg::DIM_W-1]};
    assign th = {rh_reg, qh_reg[psnr3_pkg::DIM_W-1]};
    assign gw = tw >= {1'b0, cfg.div_h};
    assign gh = th >= {1'b0, cfg.div_v};

    // pixel count of the current plane, clamped to one .. 2^MAX_PIXELS_LOG2
    always_comb
    begin
        pels_sel = (k_reg == 2'd0) ? luma_pels_reg : chroma_pels_reg;
        if (pels_sel == '0)
            pels_clamped = psnr3_pkg::CPELS_W'(1);
        else if (pels_sel > psnr3_pkg::PELS_W'(1 << psnr3_pkg::MAX_PIXELS_LOG2))
            pels_clamped = psnr3_pkg::CPELS_W'(1 << psnr3_pkg::MAX_PIXELS_LOG2);
        else
            pels_clamped = pels_sel[psnr3_pkg::CPELS_W-1:0];
    end

    assign cur_sum  = head.sums[k_reg];
    assign diff     = {1'b0, ln_reg} - {1'b0, log_rsp.result};
    assign rounded  = {1'b0, prod_reg} + (psnr3_pkg::PROD_W+1)'(64'h8000_0000);
    assign out_free = !out_valid_reg || results.ready;

    assign log_req.start = (state_reg == psnr3_pkg::B_SN) || (state_reg == psnr3_pkg::B_SS);
    assign log_req.value = (state_reg == psnr3_pkg::B_SN) ? num_reg : cur_sum;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psnr3_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and queue pop
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            psnr3_pkg::B_IDLE:
                if (head_valid)
                    state_next = psnr3_pkg::B_DIV;
            psnr3_pkg::B_DIV:
                if (cnt_reg == 4'(psnr3_pkg::DIM_W - 1))
                    state_next = psnr3_pkg::B_PELS;
            psnr3_pkg::B_PELS:
                state_next = psnr3_pkg::B_NUM;
            psnr3_pkg::B_NUM:
                state_next = (cur_sum == '0) ? psnr3_pkg::B_NEXT : psnr3_pkg::B_SN;
            psnr3_pkg::B_SN:
                state_next = psnr3_pkg::B_WN;
            psnr3_pkg::B_WN:
                if (log_rsp.done)
                    state_next = psnr3_pkg::B_SS;
            psnr3_pkg::B_SS:
                state_next = psnr3_pkg::B_WS;
            psnr3_pkg::B_WS:
                if (log_rsp.done)
                    state_next = (!diff[psnr3_pkg::LOG_W] && diff != '0)
                               ? psnr3_pkg::B_SCALE : psnr3_pkg::B_NEXT;
            psnr3_pkg::B_SCALE:
                state_next = psnr3_pkg::B_ROUND;
            psnr3_pkg::B_ROUND:
                state_next = psnr3_pkg::B_NEXT;
            psnr3_pkg::B_NEXT:
                state_next = (k_reg == 2'd2) ? psnr3_pkg::B_OUT : psnr3_pkg::B_NUM;
            psnr3_pkg::B_OUT:
                if (out_free)
                begin
                    pop        = 1'b1;
                    state_next = psnr3_pkg::B_IDLE;
                end
            default:
                state_next = psnr3_pkg::B_IDLE;
        endcase
    end

    // per-frame datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            psnr3_pkg::B_IDLE:
            begin
                qw_reg   <= cfg.width;
                qh_reg   <= cfg.height;
                rw_reg   <= '0;
                rh_reg   <= '0;
                cnt_reg  <= '0;
                k_reg    <= 2'd0;
                mask_reg <= '0;
            end
            psnr3_pkg::B_DIV:
            begin
                rw_reg  <= gw ? psnr3_pkg::DIV_W'(tw - {1'b0, cfg.div_h})
                              : tw[psnr3_pkg::DIV_W-1:0];
                rh_reg  <= gh ? psnr3_pkg::DIV_W'(th - {1'b0, cfg.div_v})
                              : th[psnr3_pkg::DIV_W-1:0];
                qw_reg  <= {qw_reg[psnr3_pkg::DIM_W-2:0], gw};
                qh_reg  <= {qh_reg[psnr3_pkg::DIM_W-2:0], gh};
                cnt_reg <= cnt_reg + 1'b1;
            end
            psnr3_pkg::B_PELS:
            begin
                luma_pels_reg   <= cfg.width * cfg.height;
                chroma_pels_reg <= qw_reg * qh_reg;
                pk2_reg         <= cfg.peak * cfg.peak;
            end
            psnr3_pkg::B_NUM:
            begin
                num_reg <= psnr3_pkg::SUM_W'(pk2_reg * pels_clamped);
                if (cur_sum == '0)
                begin
                    psnr_reg[k_reg] <= '1;
                    mask_reg[k_reg] <= 1'b1;
                end
            end
            psnr3_pkg::B_WN:
                if (log_rsp.done)
                    ln_reg <= log_rsp.result;
            psnr3_pkg::B_WS:
                if (log_rsp.done)
                begin
                    d_reg <= diff[psnr3_pkg::LOG_W-1:0];
                    if (diff[psnr3_pkg::LOG_W] || diff == '0)
                        psnr_reg[k_reg] <= '0;
                end
            psnr3_pkg::B_SCALE:
                prod_reg <= d_reg * psnr3_pkg::TEN_LOG10_2_Q24;
            psnr3_pkg::B_ROUND:
                psnr_reg[k_reg] <= (rounded[psnr3_pkg::PROD_W:32] > 17'hFFFF)
                                 ? '1 : rounded[47:32];
            psnr3_pkg::B_NEXT:
                k_reg <= k_reg + 1'b1;
            default:
                ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_luma_reg <= psnr_reg[0];
            out_c1_reg   <= psnr_reg[1];
            out_c2_reg   <= psnr_reg[2];
            out_mask_reg <= mask_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.psnr_luma       = out_luma_reg;
    assign results.psnr_chroma_one = out_c1_reg;
    assign results.psnr_chroma_two = out_c2_reg;
    assign results.identical_mask  = out_mask_reg;

endmodule

`default_nettype wire

FILE: rtl/psnr_three_plane.sv
// ----------------------------------------------------------------------------
// psnr_three_plane
// Per-frame PSNR of luma and two chroma planes in unsigned 8.8 dB.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  : one transaction per sample pair (plane, reference, test,
//             end_of_frame); one pair per cycle is taken while ready is high.
//   results : one transaction per frame, issued after the pair marked
//             end_of_frame; held in an output register until taken.
//   cfg     : register writes (index, data), always ready; write only while
//             no frame is in flight.
//   Per frame the finish does the pixel counting and divides, plus two
//   iterative log2 runs per plane with a nonzero error sum (bit-serial
//   normalise, then sixteen square-and-adjust pairs).
//   Up to four finished frames wait in a queue; pixels stall only when the
//   queued frames and the frame ends still in flight fill it, e.g. when
//   the receiver holds ready low.
//   Reset clears the sums, the queue and the result valid flag, and loads the
//   register defaults (8 bits, 1920x1080, chroma divisors 2).
// ----------------------------------------------------------------------------
`default_nettype none

module psnr_three_plane (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psnr3_pix_if.sink   pixels,
    psnr3_res_if.source results,
    psnr3_cfg_if.sink   cfg
);

    logic [psnr3_pkg::BPS_W-1:0]    bps_reg;
    logic [psnr3_pkg::DIM_W-1:0]    width_reg;
    logic [psnr3_pkg::DIM_W-1:0]    height_reg;
    logic [psnr3_pkg::DIV_W-1:0]    div_h_reg;
    logic [psnr3_pkg::DIV_W-1:0]    div_v_reg;
    logic [psnr3_pkg::BPS_W-1:0]    bps_eff;
    logic [psnr3_pkg::SAMPLE_W:0]   peak_wide;
    psnr3_pkg::psnr_cfg_t           cfg_eff;
    psnr3_pkg::sums_push_t          push;
    psnr3_pkg::frame_sums_t         head;
    logic                           head_valid;
    logic                           pop;
    logic [psnr3_pkg::QCNT_W-1:0]   q_count;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg    <= psnr3_pkg::BPS_W'(8);
            width_reg  <= psnr3_pkg::DIM_W'(1920);
            height_reg <= psnr3_pkg::DIM_W'(1080);
            div_h_reg  <= psnr3_pkg::DIV_W'(2);
            div_v_reg  <= psnr3_pkg::DIV_W'(2);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                psnr3_pkg::CFG_BITS_PER_SAMPLE: bps_reg    <= cfg.data[psnr3_pkg::BPS_W-1:0];
                psnr3_pkg::CFG_FRAME_WIDTH:     width_reg  <= cfg.data;
                psnr3_pkg::CFG_FRAME_HEIGHT:    height_reg <= cfg.data;
                psnr3_pkg::CFG_CHROMA_DIV_H:    div_h_reg  <= cfg.data[psnr3_pkg::DIV_W-1:0];
                psnr3_pkg::CFG_CHROMA_DIV_V:    div_v_reg  <= cfg.data[psnr3_pkg::DIV_W-1:0];
                default:                        ;
            endcase
        end
    end

    // effective depth and divisors
    always_comb
    begin
        if (bps_reg == '0)
            bps_eff = psnr3_pkg::BPS_W'(1);
        else if (bps_reg > psnr3_pkg::BPS_W'(psnr3_pkg::MAX_SAMPLE_BITS))
            bps_eff = psnr3_pkg::BPS_W'(psnr3_pkg::MAX_SAMPLE_BITS);
        else
            bps_eff = bps_reg;
        peak_wide      = ((psnr3_pkg::SAMPLE_W+1)'(1) << bps_eff) - 1'b1;
        cfg_eff.peak   = peak_wide[psnr3_pkg::SAMPLE_W-1:0];
        cfg_eff.width  = width_reg;
        cfg_eff.height = height_reg;
        cfg_eff.div_h  = (div_h_reg == '0) ? psnr3_pkg::DIV_W'(1) : div_h_reg;
        cfg_eff.div_v  = (div_v_reg == '0) ? psnr3_pkg::DIV_W'(1) : div_v_reg;
    end

    psnr3_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .q_count (q_count),
        .push    (push)
    );

    psnr3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    psnr3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_eff),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

`default_nettype wire
